FILE: hdl/wheel_speed_road_condition_monitor_core_assert.svh
// ----------------------------------------------------------------------------
// wheel speed monitor assertion macros
// concurrent checks on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_ROAD_CONDITION_MONITOR_CORE_ASSERT_SVH
`define WHEEL_SPEED_ROAD_CONDITION_MONITOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define WSRCM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wsrcm assertion failed");
`define WSRCM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wsrcm assertion failed");
`else
`define WSRCM_ASSERT_IMP(lbl, ante, cons)
`define WSRCM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/wsrcm_pkg.sv
// ----------------------------------------------------------------------------
// wsrcm_pkg
// shared types, constants and helpers of the wheel speed monitor
// ----------------------------------------------------------------------------
package wsrcm_pkg;

    localparam int TICKS_PER_UPDATE = 10;
    localparam int SUM_WIDTH        = 32;
    localparam int DIV_CNT_W        = $clog2(SUM_WIDTH);

    localparam int SPD_W            = 9;
    localparam int CNT16_W          = 16;
    localparam int TICK_W           = 8;
    localparam int THR_W            = 11;
    localparam int TIMER_W          = 16;
    localparam int STATUS_W         = 3;

    localparam int DEBOUNCE_GAP     = 50;
    localparam int SPEED_PER_PULSE  = 6;
    localparam int SPEED_LIMIT      = 500;
    localparam int CNT_LIMIT        = (SPEED_LIMIT + SPEED_PER_PULSE - 1) / SPEED_PER_PULSE;
    localparam int CNT_W            = $clog2(CNT_LIMIT);
    localparam int SLIP_MIN_FRONT   = 180;
    localparam int BUMPY_LO         = 50;
    localparam int BUMPY_HI         = 100;
    localparam int MUDDY_LO         = 110;
    localparam int MUDDY_HI         = 150;

    localparam int APB_ADDR_W       = 5;
    localparam int APB_DATA_W       = 32;
    localparam int REG_IDX_W        = 3;

    localparam int S_TDATA_W        = 24;
    localparam int S_TUSER_W        = 2;
    localparam int M_TDATA_W        = 88;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FAULT_THR  = 3'd0,
        REG_LOCK_THR   = 3'd1,
        REG_WINDOW     = 3'd2,
        REG_ECHO_THR   = 3'd3,
        REG_RELOAD     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        FUNC_FRONT = 2'd0,
        FUNC_REAR  = 2'd1,
        FUNC_TICK  = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ROAD_FLAT  = 3'd0,
        ROAD_LOCK  = 3'd1,
        ROAD_SLIP  = 3'd2,
        ROAD_MUDDY = 3'd3,
        ROAD_BUMPY = 3'd4
    } road_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        logic [THR_W-1:0]   fault_thr;
        logic [THR_W-1:0]   lock_thr;
        logic [TICK_W-1:0]  window_ticks;
        logic [CNT16_W-1:0] echo_thr;
        logic [TIMER_W-1:0] timer_reload;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [CNT16_W-1:0] sat_inc16(input logic [CNT16_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [SPD_W-1:0] pulse_speed(input logic [CNT_W-1:0] c);
        return SPD_W'(c * SPD_W'(SPEED_PER_PULSE));
    endfunction

endpackage

FILE: hdl/wsrcm_cfg.sv
// ----------------------------------------------------------------------------
// wsrcm_cfg
// apb register file holding thresholds, window length and timer reload
// ----------------------------------------------------------------------------
module wsrcm_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wsrcm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wsrcm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wsrcm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output wsrcm_pkg::cfg_t                    cfg
);

    wsrcm_pkg::cfg_t      cfg_reg;
    wsrcm_pkg::cfg_t      cfg_next;
    wsrcm_pkg::reg_idx_t  idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = wsrcm_pkg::reg_idx_t'(paddr[wsrcm_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                wsrcm_pkg::REG_FAULT_THR: cfg_next.fault_thr    = pwdata[wsrcm_pkg::THR_W-1:0];
                wsrcm_pkg::REG_LOCK_THR:  cfg_next.lock_thr     = pwdata[wsrcm_pkg::THR_W-1:0];
                wsrcm_pkg::REG_WINDOW:    cfg_next.window_ticks = pwdata[wsrcm_pkg::TICK_W-1:0];
                wsrcm_pkg::REG_ECHO_THR:  cfg_next.echo_thr     = pwdata[wsrcm_pkg::CNT16_W-1:0];
                wsrcm_pkg::REG_RELOAD:    cfg_next.timer_reload = pwdata[wsrcm_pkg::TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            wsrcm_pkg::REG_FAULT_THR: prdata = wsrcm_pkg::APB_DATA_W'(cfg_reg.fault_thr);
            wsrcm_pkg::REG_LOCK_THR:  prdata = wsrcm_pkg::APB_DATA_W'(cfg_reg.lock_thr);
            wsrcm_pkg::REG_WINDOW:    prdata = wsrcm_pkg::APB_DATA_W'(cfg_reg.window_ticks);
            wsrcm_pkg::REG_ECHO_THR:  prdata = wsrcm_pkg::APB_DATA_W'(cfg_reg.echo_thr);
            wsrcm_pkg::REG_RELOAD:    prdata = wsrcm_pkg::APB_DATA_W'(cfg_reg.timer_reload);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fault_thr    <= wsrcm_pkg::THR_W'(1200);
            cfg_reg.lock_thr     <= wsrcm_pkg::THR_W'(750);
            cfg_reg.window_ticks <= '0;
            cfg_reg.echo_thr     <= '0;
            cfg_reg.timer_reload <= wsrcm_pkg::TIMER_W'(39062);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/wsrcm_div.sv
// ----------------------------------------------------------------------------
// wsrcm_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wsrcm_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [wsrcm_pkg::SUM_WIDTH-1:0]   dividend,
    input  logic [wsrcm_pkg::SUM_WIDTH-1:0]   divisor,
    output logic [wsrcm_pkg::SUM_WIDTH-1:0]   quotient,
    output wsrcm_pkg::div_stat_t              stat
);

    localparam int W = wsrcm_pkg::SUM_WIDTH;

    logic [W-1:0]                     rem_reg,  rem_next;
    logic [W-1:0]                     quo_reg,  quo_next;
    logic [W-1:0]                     dvs_reg,  dvs_next;
    logic [wsrcm_pkg::DIV_CNT_W-1:0]  cnt_reg,  cnt_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [W:0]                       shifted;
    logic [W:0]                       diff;

    assign shifted   = {rem_reg, quo_reg[W-1]};
    assign diff      = shifted - {1'b0, dvs_reg};
    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = wsrcm_pkg::DIV_CNT_W'(W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], ~diff[W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

FILE: hdl/wheel_speed_road_condition_monitor_core.sv
// each request is emitted through the EMIT state; a speed update that recomputes the average passes through DIV first
// requests are taken only in IDLE, one at a time, so the next waits until the previous reaches the output register
// the average comes from a 32-step serial divider, one quotient bit per cycle
// a new request is taken while the previous result still waits in the output register
// reset: synchronous active low, clears all counters, speeds, status and the state and valid registers
// ----------------------------------------------------------------------------
// wheel_speed_road_condition_monitor_core
// wheel pulse debounce, speed, lock/slip and road condition classification
// ----------------------------------------------------------------------------
`include "wheel_speed_road_condition_monitor_core_assert.svh"

module wheel_speed_road_condition_monitor_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: timer_value[15:0], echo_low[16], zero pad
    input  logic [wsrcm_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: func[1:0]
    input  logic [wsrcm_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: road_status[2:0], front_speed[11:3], rear_speed[20:12], top_speed[29:21],
    //        average_speed[38:30], flat_windows[54:39], muddy_windows[70:55],
    //        bumpy_windows[86:71], zero pad
    output logic [wsrcm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wsrcm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wsrcm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wsrcm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int SW = wsrcm_pkg::SUM_WIDTH;
    localparam int PW = wsrcm_pkg::SPD_W;
    localparam int CW = wsrcm_pkg::CNT16_W;
    localparam int TW = wsrcm_pkg::TICK_W;

    wsrcm_pkg::cfg_t       cfg;
    wsrcm_pkg::div_stat_t  div_stat;
    logic [SW-1:0]         div_quo;
    wsrcm_pkg::state_t     state_reg, state_next;
    wsrcm_pkg::func_t      func;

    logic [CW-1:0]  front_cnt_reg, front_cnt_next;
    logic [CW-1:0]  rear_cnt_reg,  rear_cnt_next;
    logic [wsrcm_pkg::TIMER_W-1:0] last_time_reg, last_time_next;
    logic [TW-1:0]  sec_cnt_reg,   sec_cnt_next;
    logic [TW-1:0]  win_cnt_reg,   win_cnt_next;
    logic [CW-1:0]  echo_cnt_reg,  echo_cnt_next;
    logic [PW-1:0]  front_spd_reg, front_spd_next;
    logic [PW-1:0]  rear_spd_reg,  rear_spd_next;
    logic [PW-1:0]  top_spd_reg,   top_spd_next;
    logic [PW-1:0]  avg_spd_reg,   avg_spd_next;
    logic [SW-1:0]  sum_reg,       sum_next;
    logic [SW-1:0]  moving_reg,    moving_next;
    logic [wsrcm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]  flat_reg,      flat_next;
    logic [CW-1:0]  muddy_reg,     muddy_next;
    logic [CW-1:0]  bumpy_reg,     bumpy_next;
    logic [wsrcm_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic           out_valid_reg, out_valid_next;

    logic           in_accept;
    logic           need_div;
    logic           div_start;
    logic           out_load;

    wsrcm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wsrcm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (moving_next),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign func      = wsrcm_pkg::func_t'(s_tuser);
    assign in_accept = s_tvalid && s_tready;
    assign m_tdata   = out_data_reg;
    assign m_tvalid  = out_valid_reg;

    // event datapath
    always_comb begin
        logic [wsrcm_pkg::TIMER_W-1:0] sample;
        logic signed [wsrcm_pkg::TIMER_W+1:0] gap;
        logic [TW-1:0]  sec_inc;
        logic [TW-1:0]  win_inc;
        logic [SW:0]    sum_wide;
        logic signed [wsrcm_pkg::THR_W:0] diff;
        logic           rough;

        front_cnt_next = front_cnt_reg;
        rear_cnt_next  = rear_cnt_reg;
        last_time_next = last_time_reg;
        sec_cnt_next   = sec_cnt_reg;
        win_cnt_next   = win_cnt_reg;
        echo_cnt_next  = echo_cnt_reg;
        front_spd_next = front_spd_reg;
        rear_spd_next  = rear_spd_reg;
        top_spd_next   = top_spd_reg;
        avg_spd_next   = avg_spd_reg;
        sum_next       = sum_reg;
        moving_next    = moving_reg;
        status_next    = status_reg;
        flat_next      = flat_reg;
        muddy_next     = muddy_reg;
        bumpy_next     = bumpy_reg;
        need_div       = 1'b0;

        sample   = s_tdata[wsrcm_pkg::TIMER_W-1:0];
        sec_inc  = sec_cnt_reg + 1'b1;
        win_inc  = win_cnt_reg + 1'b1;
        gap      = '0;
        sum_wide = '0;
        diff     = '0;
        rough    = 1'b0;

        if (in_accept) begin
            unique case (func)
                wsrcm_pkg::FUNC_FRONT: begin
                    front_cnt_next = wsrcm_pkg::sat_inc16(front_cnt_reg);
                end
                wsrcm_pkg::FUNC_REAR: begin
                    if (sample < last_time_reg) begin
                        gap = $signed({2'b00, last_time_reg}) - $signed({2'b00, sample});
                    end else begin
                        gap = $signed({2'b00, cfg.timer_reload}) - $signed({2'b00, sample})
                            + $signed({2'b00, last_time_reg});
                    end
                    if (gap > $signed((wsrcm_pkg::TIMER_W+2)'(wsrcm_pkg::DEBOUNCE_GAP))) begin
                        rear_cnt_next = wsrcm_pkg::sat_inc16(rear_cnt_reg);
                    end
                    last_time_next = sample;
                end
                wsrcm_pkg::FUNC_TICK: begin
                    sec_cnt_next = sec_inc;
                    win_cnt_next = win_inc;
                    if (sec_inc == TW'(wsrcm_pkg::TICKS_PER_UPDATE)) begin
                        sec_cnt_next = '0;
                        if (front_cnt_reg < CW'(wsrcm_pkg::CNT_LIMIT)) begin
                            front_spd_next = wsrcm_pkg::pulse_speed(
                                front_cnt_reg[wsrcm_pkg::CNT_W-1:0]);
                        end
                        if (rear_cnt_reg < CW'(wsrcm_pkg::CNT_LIMIT)) begin
                            rear_spd_next = wsrcm_pkg::pulse_speed(
                                rear_cnt_reg[wsrcm_pkg::CNT_W-1:0]);
                        end
                        if (rear_spd_next > top_spd_reg) begin
                            top_spd_next = rear_spd_next;
                        end
                        if (rear_spd_next != '0) begin
                            if (moving_reg != '1) begin
                                moving_next = moving_reg + 1'b1;
                            end
                            sum_wide = {1'b0, sum_reg} + (SW+1)'(rear_spd_next);
                            sum_next = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
                            need_div = 1'b1;
                        end
                        diff = $signed({3'b000, front_spd_next}) - $signed({3'b000, rear_spd_next});
                        if (diff >= $signed({1'b0, cfg.fault_thr})) begin
                            if (diff >= $signed({1'b0, cfg.lock_thr})) begin
                                status_next = wsrcm_pkg::ROAD_LOCK;
                            end else if (front_spd_next >= PW'(wsrcm_pkg::SLIP_MIN_FRONT)) begin
                                status_next = wsrcm_pkg::ROAD_SLIP;
                            end
                        end
                        front_cnt_next = '0;
                        rear_cnt_next  = '0;
                    end
                    if (s_tdata[wsrcm_pkg::TIMER_W]) begin
                        echo_cnt_next = wsrcm_pkg::sat_inc16(echo_cnt_reg);
                    end
                    if (win_inc == cfg.window_ticks) begin
                        rough = (echo_cnt_next >= cfg.echo_thr);
                        if (rough) begin
                            if (rear_spd_next >= PW'(wsrcm_pkg::BUMPY_LO) &&
                                rear_spd_next <= PW'(wsrcm_pkg::BUMPY_HI)) begin
                                bumpy_next  = wsrcm_pkg::sat_inc16(bumpy_reg);
                                status_next = wsrcm_pkg::ROAD_BUMPY;
                            end else if (rear_spd_next >= PW'(wsrcm_pkg::MUDDY_LO) &&
                                         rear_spd_next <= PW'(wsrcm_pkg::MUDDY_HI)) begin
                                muddy_next  = wsrcm_pkg::sat_inc16(muddy_reg);
                                status_next = wsrcm_pkg::ROAD_MUDDY;
                            end
                        end else begin
                            status_next = wsrcm_pkg::ROAD_FLAT;
                            if (rear_spd_next != '0) begin
                                flat_next = wsrcm_pkg::sat_inc16(flat_reg);
                            end
                        end
                        win_cnt_next  = '0;
                        echo_cnt_next = '0;
                    end
                end
                default: ;
            endcase
        end

        if (state_reg == wsrcm_pkg::ST_DIV && div_stat.done) begin
            avg_spd_next = div_quo[PW-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wsrcm_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = need_div ? wsrcm_pkg::ST_DIV : wsrcm_pkg::ST_EMIT;
                end
            end
            wsrcm_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = wsrcm_pkg::ST_EMIT;
                end
            end
            wsrcm_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = wsrcm_pkg::ST_IDLE;
                end
            end
            default: state_next = wsrcm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = (state_reg == wsrcm_pkg::ST_IDLE);
        div_start = in_accept && need_div;
        out_load  = (state_reg == wsrcm_pkg::ST_EMIT) && (!out_valid_reg || m_tready);
    end

    // output register
    always_comb begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, bumpy_reg, muddy_reg, flat_reg, avg_spd_reg,
                              top_spd_reg, rear_spd_reg, front_spd_reg, status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wsrcm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            front_cnt_reg <= '0;
            rear_cnt_reg  <= '0;
            last_time_reg <= '0;
            sec_cnt_reg   <= '0;
            win_cnt_reg   <= '0;
            echo_cnt_reg  <= '0;
            front_spd_reg <= '0;
            rear_spd_reg  <= '0;
            top_spd_reg   <= '0;
            avg_spd_reg   <= '0;
            sum_reg       <= '0;
            moving_reg    <= '0;
            status_reg    <= wsrcm_pkg::ROAD_FLAT;
            flat_reg      <= '0;
            muddy_reg     <= '0;
            bumpy_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            front_cnt_reg <= front_cnt_next;
            rear_cnt_reg  <= rear_cnt_next;
            last_time_reg <= last_time_next;
            sec_cnt_reg   <= sec_cnt_next;
            win_cnt_reg   <= win_cnt_next;
            echo_cnt_reg  <= echo_cnt_next;
            front_spd_reg <= front_spd_next;
            rear_spd_reg  <= rear_spd_next;
            top_spd_reg   <= top_spd_next;
            avg_spd_reg   <= avg_spd_next;
            sum_reg       <= sum_next;
            moving_reg    <= moving_next;
            status_reg    <= status_next;
            flat_reg      <= flat_next;
            muddy_reg     <= muddy_next;
            bumpy_reg     <= bumpy_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    `WSRCM_ASSERT_IMP(a_avg_not_above_top, 1'b1, avg_spd_reg <= top_spd_reg)
    `WSRCM_ASSERT_NXT(a_one_request_at_a_time, in_accept, !s_tready)
    `WSRCM_ASSERT_IMP(a_div_only_in_div, div_stat.busy || div_stat.done, state_reg == wsrcm_pkg::ST_DIV)

endmodule
